>>> rtl/core/mks_pkg.sv
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants of the matrix keypad scanner
// register map codes, keypad limits and field widths
// ----------------------------------------------------------------------------
`default_nettype none

package mks_pkg;

	// keypad limits
	localparam int unsigned MAX_ROWS = 4;
	localparam int unsigned MAX_COLS = 4;

	// field widths
	localparam int unsigned ROW_W    = 4;
	localparam int unsigned COL_W    = 4;
	localparam int unsigned CNT_W    = 3;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned CODE_W   = 8;
	localparam int unsigned TOTAL_W  = 32;
	localparam int unsigned ADDR_W   = 6;
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned TABLE_W  = 128;

	// register indexes (byte address is 8 * index)
	typedef enum logic [2:0] {
		REG_ROW_COUNT      = 3'd0,
		REG_COL_COUNT      = 3'd1,
		REG_SETTLE_TICKS   = 3'd2,
		REG_DEBOUNCE_TICKS = 3'd3,
		REG_KEY_TABLE_LOW  = 3'd4,
		REG_KEY_TABLE_HIGH = 3'd5
	} reg_index_t;

	// a count of zero counts as one, above the maximum counts as the maximum
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] maxv);
		logic [CNT_W-1:0] r;
		begin
			r = v;
			if (v == '0) begin
				r = CNT_W'(1);
			end else if (v > maxv) begin
				r = maxv;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/matrix_keypad_scanner.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner: column-driven keypad scan with settle and debounce
// one tick word in, one result word out, scan state kept in flops
// ----------------------------------------------------------------------------
// data path: a tick word is taken into the input register (s1), and its result word is
//   registered in the result register when the scan step runs
// throughput: one tick word per cycle while the receiver takes result words; the scan
//   step is one pass of logic between the input register and the result register
// reset (arst_n low): scan at column 0, row 0, no wait, no key, count 0,
//   registers at their defaults (4 rows, 4 columns, settle 1, debounce 20)
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_scanner
	import mks_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic      [DATA_W-1:0]   prdata,
	output logic                     pready,
	// tick channel
	input  wire logic                tick_valid,
	output logic                     tick_ready,
	input  wire logic [ROW_W-1:0]    row_levels,
	// result channel
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic      [COL_W-1:0]    column_drive,
	output logic                     key_valid,
	output logic      [CODE_W-1:0]   key_code,
	output logic      [CODE_W-1:0]   last_key,
	output logic      [TOTAL_W-1:0]  press_count
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]   row_count_q;
	logic [CNT_W-1:0]   col_count_q;
	logic [TICK_W-1:0]  settle_ticks_q;
	logic [TICK_W-1:0]  debounce_ticks_q;
	logic [DATA_W-1:0]  key_table_low_q;
	logic [DATA_W-1:0]  key_table_high_q;
	logic               cfg_write;
	reg_index_t         cfg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	// registers sit on 8-byte boundaries, the low address bits are ignored
	assign cfg_index = reg_index_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q      <= CNT_W'(4);
			col_count_q      <= CNT_W'(4);
			settle_ticks_q   <= TICK_W'(1);
			debounce_ticks_q <= TICK_W'(20);
			key_table_low_q  <= '0;
			key_table_high_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW_COUNT:      row_count_q      <= pwdata[CNT_W-1:0];
				REG_COL_COUNT:      col_count_q      <= pwdata[CNT_W-1:0];
				REG_SETTLE_TICKS:   settle_ticks_q   <= pwdata[TICK_W-1:0];
				REG_DEBOUNCE_TICKS: debounce_ticks_q <= pwdata[TICK_W-1:0];
				REG_KEY_TABLE_LOW:  key_table_low_q  <= pwdata;
				REG_KEY_TABLE_HIGH: key_table_high_q <= pwdata;
				default: ; // writes beyond the map are dropped
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		case (cfg_index)
			REG_ROW_COUNT:      prdata = DATA_W'(row_count_q);
			REG_COL_COUNT:      prdata = DATA_W'(col_count_q);
			REG_SETTLE_TICKS:   prdata = DATA_W'(settle_ticks_q);
			REG_DEBOUNCE_TICKS: prdata = DATA_W'(debounce_ticks_q);
			REG_KEY_TABLE_LOW:  prdata = key_table_low_q;
			REG_KEY_TABLE_HIGH: prdata = key_table_high_q;
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// handshake: input register (s1) feeding the result register
	// the scan step runs when s1 holds a word and the result slot is free
	// or is being emptied in the same cycle
	// ------------------------------------------------------------------
	logic              valid_s1;
	logic [ROW_W-1:0]  levels_s1;
	logic              advance;
	logic              tick_accept;

	assign advance     = valid_s1 && (!result_valid || result_ready);
	assign tick_ready  = !valid_s1 || advance;
	assign tick_accept = tick_valid && tick_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_accept) begin
			levels_s1 <= row_levels;
		end
	end

	// ------------------------------------------------------------------
	// scan state
	// ------------------------------------------------------------------
	logic [1:0]          cur_col_q;     // column being driven
	logic [2:0]          resume_row_q;  // first row to look at, 0..4
	logic [TICK_W-1:0]   wait_q;        // settle or debounce ticks left
	logic [CODE_W-1:0]   held_key_q;
	logic [TOTAL_W-1:0]  press_total_q;

	// ------------------------------------------------------------------
	// scan step
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]    rows;
	logic [CNT_W-1:0]    cols;
	logic [ROW_W-1:0]    row_en;
	logic [ROW_W-1:0]    hits;
	logic                col_ok;
	logic                hit;
	logic [1:0]          hit_row;
	logic [3:0]          key_idx;
	logic [TABLE_W-1:0]  key_table;
	logic [CODE_W-1:0]   found_code;
	logic [CNT_W-1:0]    next_col;
	logic                scan;

	assign rows   = clamp_count(row_count_q, CNT_W'(MAX_ROWS));
	assign cols   = clamp_count(col_count_q, CNT_W'(MAX_COLS));
	// a column at or above the count after col_count was lowered finds nothing
	assign col_ok = {1'b0, cur_col_q} < cols;
	assign scan   = (wait_q == '0);

	// rows at or after the resume point and below the row count
	always_comb begin
		for (int r = 0; r < ROW_W; r++) begin
			row_en[r] = (CNT_W'(r) >= resume_row_q) && (CNT_W'(r) < rows);
		end
	end

	assign hits = col_ok ? (levels_s1 & row_en) : '0;
	assign hit  = |hits;

	// lowest high row
	always_comb begin
		hit_row = 2'd0;
		for (int r = ROW_W - 1; r >= 0; r--) begin
			if (hits[r]) begin
				hit_row = 2'(r);
			end
		end
	end

	// row * cols + col stays below 16 with both counts at most 4
	assign key_idx    = ({2'b00, hit_row} * {1'b0, cols}) + {2'b00, cur_col_q};
	assign key_table  = {key_table_high_q, key_table_low_q};
	assign found_code = key_table[key_idx*CODE_W +: CODE_W];
	assign next_col   = ({1'b0, cur_col_q} + CNT_W'(1) >= cols)
		? '0 : ({1'b0, cur_col_q} + CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q     <= '0;
			resume_row_q  <= '0;
			wait_q        <= '0;
			held_key_q    <= '0;
			press_total_q <= '0;
		end else if (advance) begin
			if (!scan) begin
				wait_q <= wait_q - TICK_W'(1);
			end else if (hit) begin
				// press: report it, then debounce before the next row
				held_key_q    <= found_code;
				press_total_q <= press_total_q + TOTAL_W'(1);
				resume_row_q  <= {1'b0, hit_row} + 3'd1;
				wait_q        <= debounce_ticks_q;
			end else begin
				// column done: drive the next one and let it settle
				cur_col_q    <= next_col[1:0];
				resume_row_q <= '0;
				wait_q       <= settle_ticks_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	logic  press;
	assign press = scan && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// drive reflects the column at the start of the tick
			column_drive <= COL_W'(1) << cur_col_q;
			key_valid    <= press;
			key_code     <= press ? found_code : '0;
			last_key     <= press ? found_code : held_key_q;
			press_count  <= press ? (press_total_q + TOTAL_W'(1)) : press_total_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mks_checker.sv
// ----------------------------------------------------------------------------
// mks_checker: port-level checks of the matrix keypad scanner
// result word consistency and output hold under back-pressure
// ----------------------------------------------------------------------------
`default_nettype none

module mks_checker
	import mks_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire logic [COL_W-1:0]    column_drive,
	input wire logic                key_valid,
	input wire logic [CODE_W-1:0]   key_code,
	input wire logic [CODE_W-1:0]   last_key,
	input wire logic [TOTAL_W-1:0]  press_count
);

	// exactly one column driven in every result word
	a_drive_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot(column_drive))
		else $error("column drive not one-hot");

	// no press means a zero key code
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !key_valid) |-> (key_code == '0))
		else $error("key code set without a press");

	// a press updates the last key to its own code
	a_last_key: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && key_valid) |-> (last_key == key_code))
		else $error("last key differs from reported press");

	// a stalled result word stays valid and holds its press count and key code
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=>
			(result_valid && $stable(press_count) && $stable(key_code)))
		else $error("result word changed while stalled");

endmodule

bind matrix_keypad_scanner mks_checker u_mks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.column_drive (column_drive),
	.key_valid    (key_valid),
	.key_code     (key_code),
	.last_key     (last_key),
	.press_count  (press_count)
);

`default_nettype wire

>>> tb/matrix_keypad_scanner_test.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_test: self-checking bench for the keypad scanner
// feeds tick words of row levels, predicts every result word in step with the
// scan state, and checks all five result fields under random idling, a long
// receiver hold-off, register changes between phases and the longest waits
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_scanner_test;
	import mks_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int HOLD_CYCLES  = 64;
	localparam int GAP_MAX      = 16;
	localparam int SCAN_PHASES  = 8;
	localparam int PHASE_TICKS  = 150;
	localparam int DRAIN_CYCLES = 4;

	// one result word, laid out as the result ports are
	typedef struct packed {
		logic [COL_W-1:0]   drive;
		logic               hit;
		logic [CODE_W-1:0]  code;
		logic [CODE_W-1:0]  last;
		logic [TOTAL_W-1:0] count;
	} scan_word_t;

	// one row of the directed plan: a register write or a tick word
	typedef struct packed {
		logic               is_cfg;
		reg_index_t         idx;
		logic [DATA_W-1:0]  value;
		logic [ROW_W-1:0]   levels;
		logic               typed;
		scan_word_t         want;
	} plan_step_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                tick_valid;
	logic                tick_ready;
	logic [ROW_W-1:0]    row_levels;
	logic                result_valid;
	logic                result_ready;
	logic [COL_W-1:0]    column_drive;
	logic                key_valid;
	logic [CODE_W-1:0]   key_code;
	logic [CODE_W-1:0]   last_key;
	logic [TOTAL_W-1:0]  press_count;

	// register shadow
	logic [2:0]          row_cfg;
	logic [2:0]          col_cfg;
	logic [TICK_W-1:0]   settle_cfg;
	logic [TICK_W-1:0]   debounce_cfg;
	logic [TABLE_W-1:0]  key_map;

	// scan state of the predictor
	logic [1:0]          scan_col;
	logic [2:0]          scan_row;
	logic [TICK_W-1:0]   wait_left;
	logic [CODE_W-1:0]   held_code;
	logic [TOTAL_W-1:0]  press_total;

	scan_word_t          scan_words_due[$];
	plan_step_t          plan[$];
	int                  mismatches = 0;
	int                  cycles = 0;
	bit                  tx_gaps = 1'b1;
	bit                  rx_gaps = 1'b1;
	bit                  hold_req = 1'b0;

	matrix_keypad_scanner i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.row_levels   (row_levels),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.column_drive (column_drive),
		.key_valid    (key_valid),
		.key_code     (key_code),
		.last_key     (last_key),
		.press_count  (press_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit, counted in clock cycles
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one scan tick of the predictor: advances the scan state, returns the word
	function automatic scan_word_t next_scan_word(input logic [ROW_W-1:0] lv);
		int         rows;
		int         cols;
		int         hit_row;
		int         nxt;
		int         idx;
		logic       found;
		scan_word_t w;
		// zero counts as one, anything above the limit counts as the limit
		rows = (row_cfg == 0) ? 1 : (row_cfg > MAX_ROWS) ? MAX_ROWS : int'(row_cfg);
		cols = (col_cfg == 0) ? 1 : (col_cfg > MAX_COLS) ? MAX_COLS : int'(col_cfg);
		w = '0;
		w.drive = COL_W'(1) << scan_col;
		if (wait_left != 0) begin
			// settle or debounce still running, nothing else moves
			wait_left = wait_left - 1'b1;
		end else begin
			found = 1'b0;
			hit_row = 0;
			// a column left beyond a lowered column count finds nothing
			if (int'(scan_col) < cols) begin
				for (int k = 0; k < rows; k++) begin
					if (k >= int'(scan_row) && lv[k] && !found) begin
						found = 1'b1;
						hit_row = k;
					end
				end
			end
			if (found) begin
				idx = (hit_row * cols + int'(scan_col)) % 16;
				w.hit = 1'b1;
				w.code = key_map[idx*8 +: 8];
				held_code = w.code;
				press_total = press_total + 1'b1;
				scan_row = 3'(hit_row + 1);
				wait_left = debounce_cfg;
			end else begin
				nxt = int'(scan_col) + 1;
				if (nxt >= cols) begin
					nxt = 0;
				end
				scan_col = 2'(nxt);
				scan_row = '0;
				wait_left = settle_cfg;
			end
		end
		w.last = held_code;
		w.count = press_total;
		return w;
	endfunction

	function automatic plan_step_t step_tick(input logic [ROW_W-1:0] lv);
		plan_step_t s;
		s = '0;
		s.levels = lv;
		return s;
	endfunction

	function automatic plan_step_t step_cfg(input reg_index_t idx, input logic [DATA_W-1:0] value);
		plan_step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.value = value;
		return s;
	endfunction

	// offer one tick word, predict it once it is taken
	task automatic send_tick(input logic [ROW_W-1:0] lv, input logic typed,
		input scan_word_t want);
		scan_word_t w;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		row_levels <= lv;
		@(posedge clk);
		while (!tick_ready) @(posedge clk);
		w = next_scan_word(lv);
		// a typed row stands in for the prediction, the state still advances
		scan_words_due.push_back(typed ? want : w);
	endtask

	// stop offering, let every due word come back, then a few spare cycles
	task automatic drain_scan();
		tick_valid <= 1'b0;
		while (scan_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup and access cycle, register taken at the access edge, then the bus goes idle
	task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ROW_COUNT:      row_cfg = value[2:0];
			REG_COL_COUNT:      col_cfg = value[2:0];
			REG_SETTLE_TICKS:   settle_cfg = value[TICK_W-1:0];
			REG_DEBOUNCE_TICKS: debounce_cfg = value[TICK_W-1:0];
			REG_KEY_TABLE_LOW:  key_map[63:0] = value;
			REG_KEY_TABLE_HIGH: key_map[127:64] = value;
			default: ;
		endcase
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_ready <= 1'b1;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// result checker, oldest due word first
	always @(posedge clk) begin : check_words
		scan_word_t due;
		scan_word_t seen;
		if (arst_n && result_valid && result_ready) begin
			seen = {column_drive, key_valid, key_code, last_key, press_count};
			if (scan_words_due.size() == 0) begin
				$error("result word with nothing due: %h", seen);
				mismatches++;
			end else begin
				due = scan_words_due.pop_front();
				if (seen.drive !== due.drive) begin
					$error("column_drive: expected %0h, got %0h", due.drive, seen.drive);
					mismatches++;
				end
				if (seen.hit !== due.hit) begin
					$error("key_valid: expected %0h, got %0h", due.hit, seen.hit);
					mismatches++;
				end
				if (seen.code !== due.code) begin
					$error("key_code: expected %0h, got %0h", due.code, seen.code);
					mismatches++;
				end
				if (seen.last !== due.last) begin
					$error("last_key: expected %0h, got %0h", due.last, seen.last);
					mismatches++;
				end
				if (seen.count !== due.count) begin
					$error("press_count: expected %0h, got %0h", due.count, seen.count);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_step_t          s;
		logic [ROW_W-1:0]    pressed;
		logic [ROW_W-1:0]    lv;
		logic [DATA_W-1:0]   lo_v;
		logic [DATA_W-1:0]   hi_v;
		logic [2:0]          rows_v;
		logic [2:0]          cols_v;
		logic [TICK_W-1:0]   settle_v;
		logic [TICK_W-1:0]   debounce_v;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tick_valid <= 1'b0;
		row_levels <= '0;

		// predictor starts from the reset state
		row_cfg = 3'd4;
		col_cfg = 3'd4;
		settle_cfg = 16'd1;
		debounce_cfg = 16'd20;
		key_map = '0;
		scan_col = '0;
		scan_row = '0;
		wait_left = '0;
		held_code = '0;
		press_total = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		// first tick after reset: column 0 driven, no rows high, nothing counted
		s = step_tick(4'h0);
		s.typed = 1'b1;
		s.want = {4'b0001, 1'b0, 8'h00, 8'h00, 32'd0};
		plan.push_back(s);
		// key codes 00 at index 0, 80 at index 8, ff at index 15
		plan.push_back(step_cfg(REG_KEY_TABLE_LOW, 64'h1716151413121100));
		plan.push_back(step_cfg(REG_KEY_TABLE_HIGH, 64'hff1e1d1c1b1a1980));
		// zero waits, while the settle wait of one tick is already running
		plan.push_back(step_cfg(REG_SETTLE_TICKS, 64'd0));
		plan.push_back(step_cfg(REG_DEBOUNCE_TICKS, 64'd0));
		plan.push_back(step_tick(4'h0));
		// all rows held: one press per tick down column 1, then on to column 2
		repeat (5) plan.push_back(step_tick(4'hf));
		plan.push_back(step_tick(4'h8));
		plan.push_back(step_tick(4'h8));
		plan.push_back(step_tick(4'h8));
		plan.push_back(step_tick(4'h0));
		// row count of zero means one row, the upper row bits are ignored
		plan.push_back(step_cfg(REG_ROW_COUNT, 64'd0));
		plan.push_back(step_tick(4'he));
		plan.push_back(step_tick(4'hf));
		// row count above the limit, column count of zero while on column 1
		plan.push_back(step_cfg(REG_ROW_COUNT, 64'd7));
		plan.push_back(step_cfg(REG_COL_COUNT, 64'd0));
		plan.push_back(step_tick(4'hf));
		plan.push_back(step_tick(4'hf));
		// column count above the limit, then a debounce cut short in the register
		// only: the running wait keeps its three ticks
		plan.push_back(step_cfg(REG_COL_COUNT, 64'd7));
		plan.push_back(step_cfg(REG_DEBOUNCE_TICKS, 64'd3));
		plan.push_back(step_tick(4'hf));
		plan.push_back(step_cfg(REG_DEBOUNCE_TICKS, 64'd0));
		repeat (3) plan.push_back(step_tick(4'h0));
		plan.push_back(step_tick(4'hf));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_scan();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_tick(plan[i].levels, plan[i].typed, plan[i].want);
			end
		end

		// random phases, each with its own register setting
		pressed = 4'h1;
		for (int ph = 0; ph < SCAN_PHASES; ph++) begin
			drain_scan();
			rows_v = 3'($urandom_range(0, 7));
			cols_v = 3'($urandom_range(0, 7));
			settle_v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 12))
				: 16'($urandom_range(0, 2));
			debounce_v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 12))
				: 16'($urandom_range(0, 3));
			lo_v = {$urandom, $urandom};
			hi_v = {$urandom, $urandom};
			case (ph)
				1: begin
					lo_v = '1;
					hi_v = '1;
				end
				2: begin
					rows_v = 3'd1;
					cols_v = 3'd1;
				end
				3: begin
					rows_v = 3'd4;
					cols_v = 3'd4;
					settle_v = '0;
					debounce_v = '0;
				end
				4: begin
					lo_v = '0;
					hi_v = '0;
				end
				default: ;
			endcase
			write_reg(REG_ROW_COUNT, 64'(rows_v));
			write_reg(REG_COL_COUNT, 64'(cols_v));
			write_reg(REG_SETTLE_TICKS, 64'(settle_v));
			write_reg(REG_DEBOUNCE_TICKS, 64'(debounce_v));
			write_reg(REG_KEY_TABLE_LOW, lo_v);
			write_reg(REG_KEY_TABLE_HIGH, hi_v);

			// every third phase runs without tick idling, another third without result stalls, the last two never idle
			tx_gaps = (ph < SCAN_PHASES - 2) && (ph % 3 != 2);
			rx_gaps = (ph < SCAN_PHASES - 2) && (ph % 3 != 1);
			// long result hold-off so the block backs up into the tick side
			if (ph == 1) begin
				hold_req = 1'b1;
			end

			for (int t = 0; t < PHASE_TICKS; t++) begin
				// mostly a key held for a stretch, now and then bounce noise
				if ($urandom_range(0, 15) == 0) begin
					pressed = ($urandom_range(0, 1) == 0) ? ROW_W'(1) << $urandom_range(0, 3)
						: ROW_W'($urandom_range(0, 15));
				end
				lv = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom_range(0, 15)) : pressed;
				send_tick(lv, 1'b0, '0);
			end
		end

		// longest settle and debounce in the registers
		drain_scan();
		write_reg(REG_ROW_COUNT, 64'd4);
		write_reg(REG_COL_COUNT, 64'd4);
		write_reg(REG_SETTLE_TICKS, 64'hffff);
		write_reg(REG_DEBOUNCE_TICKS, 64'hffff);
		while (wait_left != 0) send_tick(ROW_W'($urandom_range(0, 15)), 1'b0, '0);
		// no rows high: a miss starts the long settle, still counting down at the end
		send_tick(4'h0, 1'b0, '0);
		repeat (20) send_tick(ROW_W'($urandom_range(0, 15)), 1'b0, '0);

		// wind down: every due word back, then a short quiet stretch
		tick_valid <= 1'b0;
		while (scan_words_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && scan_words_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/core/mks_pkg.sv
rtl/core/matrix_keypad_scanner.sv
rtl/core/mks_checker.sv
tb/matrix_keypad_scanner_test.sv
